### hw/rtl/cdac_pkg.sv
// Shared types and constants for the CO2 decay air-change-rate core.
// Used by cdac_front, cdac_queue, cdac_back and the top level; no dependencies.
package cdac_pkg;

	localparam int MAX_SAMPLES_DEF  = 2048;
	localparam int LN_FRAC_BITS_DEF = 12;

	localparam int PPM_W     = 16;
	localparam int CNT_W     = 12;
	localparam int ACH_W     = 14;
	localparam int CFG_W     = 16;
	localparam int CFG_AW    = 3;
	localparam int LOG2_FRAC = 20;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	// 60 minutes per hour times 2^8 for Q6.8
	localparam logic [63:0] ACH_SCALE = 64'd15360;
	localparam int DIV_BITS  = 15;
	localparam int Q_DEPTH   = 2;

	typedef enum logic [CFG_AW-1:0] {
		REG_OUTDOOR  = 3'd0,
		REG_RISE_TOL = 3'd1,
		REG_MIN_RUN  = 3'd2,
		REG_MIN_EXC  = 3'd3,
		REG_MIN_DROP = 3'd4,
		REG_MIN_R2   = 3'd5,
		REG_MAX_ACH  = 3'd6
	} reg_idx_e;

	typedef enum logic [2:0] {
		FAIL_OK     = 3'd0,
		FAIL_NO_RUN = 3'd1,
		FAIL_FEW    = 3'd2,
		FAIL_EXCESS = 3'd3,
		FAIL_DROP   = 3'd4,
		FAIL_DEGEN  = 3'd5,
		FAIL_FIT    = 3'd6,
		FAIL_RANGE  = 3'd7
	} fail_e;

	typedef struct packed {
		logic [10:0] outdoor;
		logic [9:0]  rise_tol;
		logic [7:0]  min_run;
		logic [13:0] min_exc;
		logic [13:0] min_drop;
		logic [15:0] min_r2;
		logic [13:0] max_ach;
	} cfg_t;

	// One classified sample, in the order the back end applies the steps
	typedef struct packed {
		logic [PPM_W-1:0] ppm;
		logic             copy_a;  // keep current run before a restart or gap
		logic             start;   // open a new run
		logic             fit;     // valid sample, offer it to the fit
		logic             copy_b;  // keep current run on the final sample
		logic             last;    // judge and clear afterwards
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### hw/rtl/cdac_front.sv
// Front end: takes sample words, tracks run boundaries and classifies each sample.
// Depends on cdac_pkg; pushes cmd_t words into cdac_queue.
module cdac_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cdac_pkg::cfg_t         cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [cdac_pkg::PPM_W-1:0] ppm,
	input  logic                   smp_valid,
	input  logic                   smp_last,
	input  cdac_pkg::q_stat_t      q_stat,
	output logic                   push,
	output cdac_pkg::cmd_t         cmd
);
	import cdac_pkg::*;

	logic [CNT_W-1:0] cnt_q, start_q, cnt_n, start_n, len1, len2;
	logic [PPM_W-1:0] prev_q;
	logic             active_q, active_n, rise, do_start;

	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		rise     = {1'b0, ppm} > ({1'b0, prev_q} + {7'b0, cfg.rise_tol});
		len1     = cnt_q - start_q;
		cnt_n    = cnt_q + 1'b1;
		do_start = smp_valid && (!active_q || rise);
		active_n = smp_valid;
		start_n  = do_start ? cnt_q : start_q;
		len2     = cnt_n - start_n;
		cmd.ppm    = ppm;
		cmd.copy_a = active_q && (len1 >= {4'b0, cfg.min_run}) && (!smp_valid || rise);
		cmd.start  = do_start;
		cmd.fit    = smp_valid;
		cmd.copy_b = smp_last && active_n && (len2 >= {4'b0, cfg.min_run});
		cmd.last   = smp_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			start_q  <= '0;
			prev_q   <= '0;
			active_q <= 1'b0;
		end else if (push) begin
			if (smp_last) begin
				cnt_q    <= '0;
				start_q  <= '0;
				prev_q   <= '0;
				active_q <= 1'b0;
			end else begin
				cnt_q    <= cnt_n;
				start_q  <= start_n;
				active_q <= active_n;
				if (smp_valid) begin
					prev_q <= ppm;
				end
			end
		end
	end

endmodule

### hw/rtl/cdac_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on cdac_pkg for cmd_t, q_stat_t and the depth.
module cdac_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cdac_pkg::cmd_t    wr_cmd,
	input  logic              pop,
	output cdac_pkg::cmd_t    rd_cmd,
	output cdac_pkg::q_stat_t stat
);
	import cdac_pkg::*;

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	cmd_t          mem_q [Q_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign rd_cmd     = mem_q[rp_q];
	assign stat.full  = (cnt_q == CW'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/cdac_back.sv
// Back end: log unit, least-squares accumulation, run bookkeeping and the judge
// with a serial multiplier and restoring divider. Depends on cdac_pkg.
module cdac_back #(
	parameter int MAX_SAMPLES  = cdac_pkg::MAX_SAMPLES_DEF,
	parameter int LN_FRAC_BITS = cdac_pkg::LN_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cdac_pkg::cfg_t             cfg,
	input  cdac_pkg::cmd_t             cmd,
	input  cdac_pkg::q_stat_t          q_stat,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cdac_pkg::ACH_W-1:0] out_ach,
	output logic                       out_ok,
	output logic [2:0]                 out_reason
);
	import cdac_pkg::*;

	localparam int NW    = $clog2(MAX_SAMPLES + 1);
	localparam int YW    = LN_FRAC_BITS + 4;
	localparam int SUMW  = 2 * YW + NW;
	localparam int MW    = (YW > NW) ? YW : NW;
	localparam int PW2   = 2 * MW;
	localparam int LNP_W = 4 + LOG2_FRAC + 32;

	typedef enum logic [3:0] {
		S_IDLE, S_PRE, S_FIT, S_LOG, S_LN, S_LNR, S_ACC1, S_ACC2, S_ACC3, S_ACC4,
		S_POST, S_J0, S_JLOAD, S_JMUL, S_DIV
	} state_e;

	typedef enum logic [3:0] {
		OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY, OP_NSXY, OP_SXSY,
		OP_MAG2, OP_RDEN, OP_RHS, OP_A, OP_LIM
	} op_e;

	state_e state_q;
	op_e    op_q;
	cmd_t   cmd_q;

	// current run
	logic [SUMW-1:0]  run_sx_q, run_sy_q, run_sxx_q, run_sxy_q, run_syy_q;
	logic [NW-1:0]    run_n_q;
	logic [PPM_W-1:0] run_first_q, run_last_q;
	logic             run_stop_q;
	// latest kept run
	logic [SUMW-1:0]  best_sx_q, best_sy_q, best_sxx_q, best_sxy_q, best_syy_q;
	logic [NW-1:0]    best_n_q;
	logic [PPM_W-1:0] best_first_q, best_last_q;
	logic             best_valid_q;

	// log unit and accumulate
	logic [30:0]       lx_q;
	logic [3:0]        lp_q;
	logic [LOG2_FRAC-1:0] frac_q;
	logic [4:0]        it_q;
	logic [LNP_W-1:0]  lnp_q;
	logic [YW-1:0]     y_q;
	logic [PW2-1:0]    prod_q;

	// judge
	logic [63:0]  t_q, den_q, deny_q, mag_q, mpb_q;
	logic         neg_q;
	logic [127:0] lhs_q, a_q, nn_q, dv_q, mac_q, mpa_q;
	logic [DIV_BITS-1:0] q_q;
	logic [3:0]   div_cnt_q;

	logic             out_valid_q, out_ok_q;
	logic [ACH_W-1:0] out_ach_q;
	logic [2:0]       out_reason_q;

	logic [PPM_W-1:0] exc;
	logic [3:0]       msb;
	logic [30:0]      x0;
	logic             above;
	logic [61:0]      lsq;
	logic [31:0]      lsh;
	logic [LNP_W:0]   lnr;
	logic [MW-1:0]    xm, ym;
	logic [63:0]      opa, opb, bden, diff;
	logic             ge;
	logic             fin;
	fail_e            fin_reason;
	logic [ACH_W-1:0] fin_ach;
	logic signed [17:0] exc_s, drop_s;

	assign out_valid  = out_valid_q;
	assign out_ach    = out_ach_q;
	assign out_ok     = out_ok_q;
	assign out_reason = out_reason_q;

	assign pop = (state_q == S_IDLE) && !q_stat.empty && (!cmd.last || !out_valid_q);

	always_comb begin
		above = cmd_q.ppm > {5'b0, cfg.outdoor};
		exc   = cmd_q.ppm - {5'b0, cfg.outdoor};
		msb   = '0;
		for (int i = 0; i < PPM_W; i++) begin
			if (exc[i]) begin
				msb = 4'(i);
			end
		end
		x0  = 31'(exc) << (5'd30 - {1'b0, msb});
		lsq = 62'(lx_q) * 62'(lx_q);
		lsh = lsq[61:30];
		lnr = (LNP_W + 1)'(lnp_q) + ((LNP_W + 1)'(1) << (LOG2_FRAC + 31 - LN_FRAC_BITS));
		xm  = MW'(run_n_q);
		ym  = MW'(y_q);
	end

	// operand select for the serial multiplier; b is the narrower side
	always_comb begin
		bden = den_q << LN_FRAC_BITS;
		unique case (op_q)
			OP_NSXX: begin opa = 64'(best_sxx_q); opb = 64'(best_n_q);  end
			OP_SXSX: begin opa = 64'(best_sx_q);  opb = 64'(best_sx_q); end
			OP_NSYY: begin opa = 64'(best_syy_q); opb = 64'(best_n_q);  end
			OP_SYSY: begin opa = 64'(best_sy_q);  opb = 64'(best_sy_q); end
			OP_NSXY: begin opa = 64'(best_sxy_q); opb = 64'(best_n_q);  end
			OP_SXSY: begin opa = 64'(best_sy_q);  opb = 64'(best_sx_q); end
			OP_MAG2: begin opa = mag_q;           opb = mag_q;          end
			OP_RDEN: begin opa = den_q;           opb = 64'(cfg.min_r2); end
			OP_RHS:  begin opa = t_q;             opb = deny_q;         end
			OP_A:    begin opa = mag_q;           opb = ACH_SCALE;      end
			OP_LIM:  begin opa = bden;            opb = 64'(cfg.max_ach); end
			default: begin opa = '0;              opb = '0;             end
		endcase
	end

	// early exits and final result of the judge
	always_comb begin
		diff   = t_q - mac_q[63:0];
		ge     = nn_q >= dv_q;
		exc_s  = $signed({2'b0, best_first_q}) - $signed({7'b0, cfg.outdoor});
		drop_s = $signed({2'b0, best_first_q}) - $signed({2'b0, best_last_q});
		fin        = 1'b0;
		fin_reason = FAIL_OK;
		fin_ach    = '0;
		case (state_q)
			S_J0: begin
				fin = 1'b1;
				if (!best_valid_q) begin
					fin_reason = FAIL_NO_RUN;
				end else if (((NW > 8) ? NW : 8)'(best_n_q) < ((NW > 8) ? NW : 8)'(cfg.min_run)) begin
					fin_reason = FAIL_FEW;
				end else if (exc_s < $signed({4'b0, cfg.min_exc})) begin
					fin_reason = FAIL_EXCESS;
				end else if (drop_s < $signed({4'b0, cfg.min_drop})) begin
					fin_reason = FAIL_DROP;
				end else begin
					fin = 1'b0;
				end
			end
			S_JMUL: begin
				if (mpb_q == '0) begin
					if (op_q == OP_SYSY && (den_q == '0 || diff == '0)) begin
						fin        = 1'b1;
						fin_reason = FAIL_DEGEN;
					end else if (op_q == OP_RHS) begin
						if (lhs_q < mac_q) begin
							fin        = 1'b1;
							fin_reason = FAIL_FIT;
						end else if (!neg_q) begin
							fin        = 1'b1;
							fin_reason = FAIL_RANGE;
						end
					end else if (op_q == OP_LIM && a_q > mac_q) begin
						fin        = 1'b1;
						fin_reason = FAIL_RANGE;
					end
				end
			end
			S_DIV: begin
				if (div_cnt_q == '0) begin
					fin     = 1'b1;
					fin_ach = {q_q[ACH_W-2:0], ge};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_NSXX;
			cmd_q        <= '0;
			run_sx_q     <= '0; run_sy_q  <= '0; run_sxx_q <= '0;
			run_sxy_q    <= '0; run_syy_q <= '0;
			run_n_q      <= '0; run_first_q <= '0; run_last_q <= '0;
			run_stop_q   <= 1'b0;
			best_sx_q    <= '0; best_sy_q  <= '0; best_sxx_q <= '0;
			best_sxy_q   <= '0; best_syy_q <= '0;
			best_n_q     <= '0; best_first_q <= '0; best_last_q <= '0;
			best_valid_q <= 1'b0;
			lx_q <= '0; lp_q <= '0; frac_q <= '0; it_q <= '0;
			lnp_q <= '0; y_q <= '0; prod_q <= '0;
			t_q <= '0; den_q <= '0; deny_q <= '0; mag_q <= '0; neg_q <= 1'b0;
			lhs_q <= '0; a_q <= '0; nn_q <= '0; dv_q <= '0;
			mac_q <= '0; mpa_q <= '0; mpb_q <= '0;
			q_q <= '0; div_cnt_q <= '0;
			out_valid_q  <= 1'b0;
			out_ok_q     <= 1'b0;
			out_ach_q    <= '0;
			out_reason_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fin) begin
				out_valid_q  <= 1'b1;
				out_ok_q     <= (fin_reason == FAIL_OK);
				out_ach_q    <= fin_ach;
				out_reason_q <= fin_reason;
				run_sx_q     <= '0; run_sy_q  <= '0; run_sxx_q <= '0;
				run_sxy_q    <= '0; run_syy_q <= '0;
				run_n_q      <= '0; run_first_q <= '0; run_last_q <= '0;
				run_stop_q   <= 1'b0;
				best_sx_q    <= '0; best_sy_q  <= '0; best_sxx_q <= '0;
				best_sxy_q   <= '0; best_syy_q <= '0;
				best_n_q     <= '0; best_first_q <= '0; best_last_q <= '0;
				best_valid_q <= 1'b0;
				state_q      <= S_IDLE;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (pop) begin
							cmd_q   <= cmd;
							state_q <= S_PRE;
						end
					end
					S_PRE: begin
						if (cmd_q.copy_a) begin
							best_sx_q    <= run_sx_q;  best_sy_q  <= run_sy_q;
							best_sxx_q   <= run_sxx_q; best_sxy_q <= run_sxy_q;
							best_syy_q   <= run_syy_q; best_n_q   <= run_n_q;
							best_first_q <= run_first_q; best_last_q <= run_last_q;
							best_valid_q <= 1'b1;
						end
						if (cmd_q.start) begin
							run_sx_q   <= '0; run_sy_q  <= '0; run_sxx_q <= '0;
							run_sxy_q  <= '0; run_syy_q <= '0;
							run_n_q    <= '0; run_first_q <= '0; run_last_q <= '0;
							run_stop_q <= 1'b0;
						end
						state_q <= S_FIT;
					end
					S_FIT: begin
						if (cmd_q.fit && !run_stop_q) begin
							if (!above || run_n_q >= NW'(MAX_SAMPLES)) begin
								run_stop_q <= 1'b1;
								state_q    <= S_POST;
							end else begin
								lx_q    <= x0;
								lp_q    <= msb;
								frac_q  <= '0;
								it_q    <= '0;
								state_q <= S_LOG;
							end
						end else begin
							state_q <= S_POST;
						end
					end
					S_LOG: begin
						lx_q   <= lsh[31] ? lsh[31:1] : lsh[30:0];
						frac_q <= {frac_q[LOG2_FRAC-2:0], lsh[31]};
						it_q   <= it_q + 1'b1;
						if (it_q == 5'(LOG2_FRAC - 1)) begin
							state_q <= S_LN;
						end
					end
					S_LN: begin
						lnp_q   <= LNP_W'({lp_q, frac_q}) * LNP_W'(LN2_Q32);
						state_q <= S_LNR;
					end
					S_LNR: begin
						y_q     <= YW'(lnr >> (LOG2_FRAC + 32 - LN_FRAC_BITS));
						state_q <= S_ACC1;
					end
					S_ACC1: begin
						prod_q  <= PW2'(xm) * PW2'(xm);
						state_q <= S_ACC2;
					end
					S_ACC2: begin
						run_sxx_q <= run_sxx_q + SUMW'(prod_q);
						prod_q    <= PW2'(xm) * PW2'(ym);
						state_q   <= S_ACC3;
					end
					S_ACC3: begin
						run_sxy_q <= run_sxy_q + SUMW'(prod_q);
						prod_q    <= PW2'(ym) * PW2'(ym);
						state_q   <= S_ACC4;
					end
					S_ACC4: begin
						run_syy_q <= run_syy_q + SUMW'(prod_q);
						run_sx_q  <= run_sx_q + SUMW'(run_n_q);
						run_sy_q  <= run_sy_q + SUMW'(y_q);
						run_n_q   <= run_n_q + 1'b1;
						if (run_n_q == '0) begin
							run_first_q <= cmd_q.ppm;
						end
						run_last_q <= cmd_q.ppm;
						state_q    <= S_POST;
					end
					S_POST: begin
						if (cmd_q.copy_b) begin
							best_sx_q    <= run_sx_q;  best_sy_q  <= run_sy_q;
							best_sxx_q   <= run_sxx_q; best_sxy_q <= run_sxy_q;
							best_syy_q   <= run_syy_q; best_n_q   <= run_n_q;
							best_first_q <= run_first_q; best_last_q <= run_last_q;
							best_valid_q <= 1'b1;
						end
						state_q <= cmd_q.last ? S_J0 : S_IDLE;
					end
					S_J0: begin
						op_q    <= OP_NSXX;
						state_q <= S_JLOAD;
					end
					S_JLOAD: begin
						mac_q   <= '0;
						mpa_q   <= {64'b0, opa};
						mpb_q   <= opb;
						state_q <= S_JMUL;
					end
					S_JMUL: begin
						if (mpb_q != '0) begin
							if (mpb_q[0]) begin
								mac_q <= mac_q + mpa_q;
							end
							mpa_q <= mpa_q << 1;
							mpb_q <= mpb_q >> 1;
						end else begin
							state_q <= S_JLOAD;
							case (op_q)
								OP_NSXX: begin t_q <= mac_q[63:0]; op_q <= OP_SXSX; end
								OP_SXSX: begin den_q <= diff;      op_q <= OP_NSYY; end
								OP_NSYY: begin t_q <= mac_q[63:0]; op_q <= OP_SYSY; end
								OP_SYSY: begin deny_q <= diff;     op_q <= OP_NSXY; end
								OP_NSXY: begin t_q <= mac_q[63:0]; op_q <= OP_SXSY; end
								OP_SXSY: begin
									neg_q <= diff[63];
									mag_q <= diff[63] ? (64'd0 - diff) : diff;
									op_q  <= OP_MAG2;
								end
								OP_MAG2: begin lhs_q <= mac_q << 16; op_q <= OP_RDEN; end
								OP_RDEN: begin t_q <= mac_q[63:0];   op_q <= OP_RHS;  end
								OP_RHS:  begin op_q <= OP_A; end
								OP_A:    begin a_q <= mac_q;         op_q <= OP_LIM;  end
								OP_LIM: begin
									nn_q      <= (a_q << 1) + {64'b0, bden};
									dv_q      <= {64'b0, bden << 1} << (DIV_BITS - 1);
									q_q       <= '0;
									div_cnt_q <= 4'(DIV_BITS - 1);
									state_q   <= S_DIV;
								end
								default: begin
								end
							endcase
						end
					end
					S_DIV: begin
						if (ge) begin
							nn_q <= nn_q - dv_q;
						end
						q_q       <= {q_q[DIV_BITS-2:0], ge};
						dv_q      <= dv_q >> 1;
						div_cnt_q <= div_cnt_q - 1'b1;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

endmodule

### hw/rtl/co2_decay_air_change_rate_core.sv
// CO2 decay air-change-rate core. A fitted sample takes 20 log squaring steps in the back end;
// the final sample adds the judge, run on a serial multiplier and a restoring divider. The back
// end takes a new word only once it is through with the last; a 2-word queue lets the input
// run ahead of the back end.
// arst_n clears all run state and loads the register defaults; no clearing pass.
module co2_decay_air_change_rate_core #(
	parameter int MAX_SAMPLES  = cdac_pkg::MAX_SAMPLES_DEF,
	parameter int LN_FRAC_BITS = cdac_pkg::LN_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] co2_ppm
	input  logic        s_tuser,   // [0] sample_valid
	input  logic        s_tlast,   // last_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [13:0] ach_q6_8, [15:14] zero
	output logic [3:0]  m_tuser,   // [0] ach_valid, [3:1] fail_reason
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import cdac_pkg::*;

	cfg_t             cfg_q;
	cmd_t             push_cmd, head_cmd;
	q_stat_t          q_stat;
	logic             push, pop, res_ok;
	logic [ACH_W-1:0] res_ach;
	logic [2:0]       res_reason;

	// configuration registers; the user must write them only while the core is idle, not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.outdoor  <= 11'd420;
			cfg_q.rise_tol <= 10'd20;
			cfg_q.min_run  <= 8'd10;
			cfg_q.min_exc  <= 14'd200;
			cfg_q.min_drop <= 14'd150;
			cfg_q.min_r2   <= 16'd52429;
			cfg_q.max_ach  <= 14'd5120;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_OUTDOOR:  cfg_q.outdoor  <= cfg_wdata[10:0];
				REG_RISE_TOL: cfg_q.rise_tol <= cfg_wdata[9:0];
				REG_MIN_RUN:  cfg_q.min_run  <= cfg_wdata[7:0];
				REG_MIN_EXC:  cfg_q.min_exc  <= cfg_wdata[13:0];
				REG_MIN_DROP: cfg_q.min_drop <= cfg_wdata[13:0];
				REG_MIN_R2:   cfg_q.min_r2   <= cfg_wdata[15:0];
				REG_MAX_ACH:  cfg_q.max_ach  <= cfg_wdata[13:0];
				default: begin
				end
			endcase
		end
	end

	// front: run boundaries and sample classification
	cdac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.ppm       (s_tdata),
		.smp_valid (s_tuser),
		.smp_last  (s_tlast),
		.q_stat    (q_stat),
		.push      (push),
		.cmd       (push_cmd)
	);

	cdac_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.pop    (pop),
		.rd_cmd (head_cmd),
		.stat   (q_stat)
	);

	// back: log, fit sums, judge; holds the result word until taken
	cdac_back #(
		.MAX_SAMPLES  (MAX_SAMPLES),
		.LN_FRAC_BITS (LN_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (head_cmd),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_ach    (res_ach),
		.out_ok     (res_ok),
		.out_reason (res_reason)
	);

	assign m_tdata = {2'b00, res_ach};
	assign m_tuser = {res_reason, res_ok};

`ifndef SYNTH
	a_ok_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] == (m_tuser[3:1] == FAIL_OK)))
		else $error("ach_valid disagrees with fail_reason");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("rejected word carries nonzero ach");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !q_stat.empty)
		else $error("accepted word missing from queue");
`endif

endmodule

### tb/tb_co2_decay_air_change_rate_core.sv
// Self-checking testbench for co2_decay_air_change_rate_core: a directed table and random
// decay sessions, with results checked against a bit-exact predictor in this file or a typed row.
// Depends on cdac_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_co2_decay_air_change_rate_core;
	import cdac_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 1050;

	typedef struct {
		logic [13:0] ach;
		logic        ach_ok;
		fail_e       why;
	} ach_word_t;

	// one row of the directed table; typed = expectation given in the row
	typedef struct {
		int    ppm;
		bit    valid;
		bit    last;
		bit    typed;
		int    ach;
		bit    ach_ok;
		fail_e why;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;   // [13:0] ach_q6_8, [15:14] zero
	logic [3:0]  m_tuser;   // [0] ach_valid, [3:1] fail_reason
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;

	co2_decay_air_change_rate_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	ach_word_t ach_expect_q[$];
	int        mismatch_cnt = 0;
	int        cyc_count = 0;
	int        rx_wait = 0;
	bit        calm = 1'b0;   // no idling on either side while set
	int        items_sent = 0;

	// ---------------- predictor state ----------------
	logic [15:0] reg_val[7];
	logic [11:0] smp_cnt, run_start;
	logic [15:0] prev_ppm;
	bit          in_run, fit_stopped, have_best;
	logic [63:0] run_sum[5], best_sum[5];   // sx, sy, sxx, sxy, syy
	logic [31:0] run_nfl[3], best_nfl[3];   // fitted points, first ppm, last ppm

	function automatic logic [15:0] reg_mask(input int idx);
		case (idx)
			REG_OUTDOOR:  return 16'h07FF;
			REG_RISE_TOL: return 16'h03FF;
			REG_MIN_RUN:  return 16'h00FF;
			REG_MIN_R2:   return 16'hFFFF;
			default:      return 16'h3FFF;
		endcase
	endfunction

	function automatic void clear_decay_state();
		smp_cnt = '0; run_start = '0; prev_ppm = '0;
		in_run = 0; fit_stopped = 0; have_best = 0;
		for (int i = 0; i < 5; i++) begin
			run_sum[i] = '0; best_sum[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			run_nfl[i] = '0; best_nfl[i] = '0;
		end
	endfunction

	// ln(e) in units of 2^-12, log2 by repeated squaring then times ln2
	function automatic logic [63:0] ln_q12(input logic [31:0] e);
		int          p;
		logic [31:0] t;
		logic [63:0] x, frac, l;
		p = 0; t = e; frac = '0;
		while (t > 1) begin
			t = t >> 1;
			p++;
		end
		x = 64'(e) << (30 - p);
		for (int i = 0; i < LOG2_FRAC; i++) begin
			x = (x * x) >> 30;
			frac = frac << 1;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				frac[0] = 1'b1;
			end
		end
		l = (64'(p) << LOG2_FRAC) | frac;
		return (l * 64'(LN2_Q32) + (64'd1 << (LOG2_FRAC + 31 - LN_FRAC_BITS_DEF)))
		       >> (LOG2_FRAC + 32 - LN_FRAC_BITS_DEF);
	endfunction

	function automatic void open_run();
		in_run = 1; run_start = smp_cnt; fit_stopped = 0;
		for (int i = 0; i < 5; i++) run_sum[i] = '0;
		for (int i = 0; i < 3; i++) run_nfl[i] = '0;
	endfunction

	function automatic void keep_long_run();
		logic [11:0] len;
		len = smp_cnt - run_start;
		if (in_run && 32'(len) >= 32'(reg_val[REG_MIN_RUN])) begin
			have_best = 1;
			best_sum = run_sum;
			best_nfl = run_nfl;
		end
	endfunction

	function automatic void add_fit_point(input logic [15:0] v);
		logic [63:0] x, y;
		if (fit_stopped) return;
		if (v <= reg_val[REG_OUTDOOR] || run_nfl[0] >= MAX_SAMPLES_DEF) begin
			fit_stopped = 1;
			return;
		end
		x = 64'(run_nfl[0]);
		y = ln_q12(32'(v) - 32'(reg_val[REG_OUTDOOR]));
		run_sum[0] += x; run_sum[1] += y; run_sum[2] += x * x;
		run_sum[3] += x * y; run_sum[4] += y * y;
		if (x == 0) run_nfl[1] = 32'(v);
		run_nfl[2] = 32'(v);
		run_nfl[0]++;
	endfunction

	function automatic fail_e judge_best(output logic [13:0] ach);
		logic [63:0]  n, den, deny, num, mag, bden, rhs64;
		logic [127:0] lhs, rhs, a, lim, nn, d, tq;
		logic [14:0]  q;
		int           c0, cf;
		ach = '0; q = '0;
		n = 64'(best_nfl[0]);
		c0 = int'(best_nfl[1]); cf = int'(best_nfl[2]);
		if (!have_best) return FAIL_NO_RUN;
		if (n < 64'(reg_val[REG_MIN_RUN])) return FAIL_FEW;
		if (c0 - int'(reg_val[REG_OUTDOOR]) < int'(reg_val[REG_MIN_EXC])) return FAIL_EXCESS;
		if (c0 - cf < int'(reg_val[REG_MIN_DROP])) return FAIL_DROP;
		den  = n * best_sum[2] - best_sum[0] * best_sum[0];
		deny = n * best_sum[4] - best_sum[1] * best_sum[1];
		if (den == 0 || deny == 0) return FAIL_DEGEN;
		num = n * best_sum[3] - best_sum[0] * best_sum[1];
		mag = num[63] ? -num : num;
		lhs = (128'(mag) * 128'(mag)) << 16;
		rhs64 = 64'(reg_val[REG_MIN_R2]) * den;
		rhs = 128'(rhs64) * 128'(deny);
		if (lhs < rhs) return FAIL_FIT;
		if (!num[63]) return FAIL_RANGE;
		a = 128'(mag) * 128'(ACH_SCALE);
		bden = den << LN_FRAC_BITS_DEF;
		lim = 128'(reg_val[REG_MAX_ACH]) * 128'(bden);
		if (a > lim) return FAIL_RANGE;
		// round to nearest: (2a + bden) / (2 bden)
		nn = (a << 1) + 128'(bden);
		d = 128'(bden << 1);
		for (int b = 14; b >= 0; b--) begin
			tq = d << b;
			if (nn >= tq) begin
				nn = nn - tq;
				q[b] = 1'b1;
			end
		end
		ach = q[13:0];
		return FAIL_OK;
	endfunction

	// advance the predictor by one sample word; returns 1 when a result is due
	function automatic bit decay_step(input logic [15:0] v, input bit valid, input bit last,
	                                  output ach_word_t res);
		fail_e why;
		logic [13:0] ach;
		res.ach = '0; res.ach_ok = 1'b0; res.why = FAIL_OK;
		if (valid) begin
			if (!in_run) begin
				open_run();
			end else if (32'(v) > 32'(prev_ppm) + 32'(reg_val[REG_RISE_TOL])) begin
				keep_long_run();
				open_run();
			end
			add_fit_point(v);
			prev_ppm = v;
		end else begin
			keep_long_run();
			in_run = 0;
		end
		smp_cnt = smp_cnt + 12'd1;
		if (!last) return 0;
		keep_long_run();
		why = judge_best(ach);
		res.ach = (why == FAIL_OK) ? ach : '0;
		res.ach_ok = (why == FAIL_OK);
		res.why = why;
		clear_decay_state();
		return 1;
	endfunction

	// ---------------- result side ----------------
	always @(posedge clk) begin
		ach_word_t exp_w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (ach_expect_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result word: data %h user %h", m_tdata, m_tuser);
				end else begin
					exp_w = ach_expect_q.pop_front();
					if (m_tdata[13:0] !== exp_w.ach || m_tdata[15:14] !== 2'b00 ||
					    m_tuser[0] !== exp_w.ach_ok || m_tuser[3:1] !== exp_w.why) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch: exp ach %0d ok %0d why %0d, got data %h ok %0d why %0d",
							         exp_w.ach, exp_w.ach_ok, exp_w.why,
							         m_tdata, m_tuser[0], m_tuser[3:1]);
					end
				end
				rx_wait = calm ? 0 : $urandom_range(0, 5);
			end
			if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------- sample side ----------------
	// Drives one word; on acceptance steps the predictor. Typed rows override the
	// predicted expectation.
	task automatic send_word(input int ppm, input bit valid, input bit last,
	                         input bit typed, input ach_word_t typed_res);
		int        gap;
		ach_word_t res;
		gap = calm ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= 16'(ppm);
		s_tuser  <= valid;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (decay_step(16'(ppm), valid, last, res))
			ach_expect_q.push_back(typed ? typed_res : res);
	endtask

	task automatic rand_word(input int ppm, input bit valid, input bit last);
		ach_word_t none;
		none.ach = '0; none.ach_ok = 1'b0; none.why = FAIL_OK;
		send_word(ppm, valid, last, 1'b0, none);
	endtask

	// hold off until the core has drained, then a margin for a word still in work
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (ach_expect_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		reg_val[idx] = val & reg_mask(idx);
	endtask

	// new register setting: each one an extreme or a value near its usual range
	task automatic new_setting();
		int pick;
		logic [15:0] v[7];
		for (int i = 0; i < 7; i++) begin
			pick = $urandom_range(0, 7);
			case (i)
				REG_OUTDOOR:  v[i] = 16'($urandom_range(300, 500));
				REG_RISE_TOL: v[i] = 16'($urandom_range(5, 60));
				REG_MIN_RUN:  v[i] = 16'($urandom_range(3, 15));
				REG_MIN_EXC:  v[i] = 16'($urandom_range(0, 300));
				REG_MIN_DROP: v[i] = 16'($urandom_range(0, 200));
				REG_MIN_R2:   v[i] = 16'($urandom_range(30000, 60000));
				default:      v[i] = 16'($urandom_range(1000, 16383));
			endcase
			if (pick == 0)
				v[i] = (i == REG_MIN_RUN) ? 16'($urandom_range(0, 2)) :
				       (i == REG_MAX_ACH) ? 16'd1 : 16'd0;
			else if (pick == 1)
				v[i] = 16'hFFFF;
		end
		for (int i = 0; i < 7; i++) write_reg(reg_idx_e'(i), v[i]);
		cfg_we <= 1'b0;
	endtask

	// one history: mostly noisy exponential decays, some noise, flat and rising runs
	task automatic random_history();
		int  kind, len, exc, v, outd;
		real k;
		bit  valid;
		kind = $urandom_range(0, 9);
		len  = $urandom_range(5, 40);
		exc  = $urandom_range(50, 4000);
		k    = $urandom_range(5, 400) / 1000.0;
		outd = reg_val[REG_OUTDOOR];
		v    = $urandom_range(0, 3000);
		for (int i = 0; i < len; i++) begin
			valid = 1'b1;
			case (kind)
				7: begin
					v = $urandom_range(0, 65535);
					valid = $urandom_range(0, 1);
				end
				8: ;  // flat level: degenerate fit
				9: v = v + $urandom_range(0, 40);
				default: begin
					v = outd + $rtoi(exc * $exp(-k * i)) + $urandom_range(0, 6) - 3;
					if ($urandom_range(0, 29) == 0) valid = 1'b0;
					if ($urandom_range(0, 29) == 0) v = v + $urandom_range(0, 500);
				end
			endcase
			if (v < 0) v = 0;
			if (v > 65535) v = 65535;
			rand_word(v, valid, i == len - 1);
		end
	endtask

	dir_row_t dir_tab[25];

	initial begin
		dir_tab[0] = '{500, 1, 1, 1, 0, 0, FAIL_NO_RUN};   // run of one sample
		dir_tab[1] = '{0, 0, 1, 1, 0, 0, FAIL_NO_RUN};     // gap only
		dir_tab[2] = '{65535, 1, 1, 1, 0, 0, FAIL_NO_RUN}; // full-scale ppm
		// ten samples below outdoor: run kept, nothing fitted
		for (int i = 3; i < 13; i++) dir_tab[i] = '{400, 1, i == 12, i == 12, 0, 0, FAIL_FEW};
		// clean decay at reset settings
		dir_tab[13] = '{2000, 1, 0, 0, 0, 0, FAIL_OK};
		dir_tab[14] = '{1842, 1, 0, 0, 0, 0, FAIL_OK};
		dir_tab[15] = '{1700, 1, 0, 0, 0, 0, FAIL_OK};
		dir_tab[16] = '{1572, 1, 0, 0, 0, 0, FAIL_OK};
		dir_tab[17] = '{1457, 1, 0, 0, 0, 0, FAIL_OK};
		dir_tab[18] = '{1353, 1, 0, 0, 0, 0, FAIL_OK};
		dir_tab[19] = '{1260, 1, 0, 0, 0, 0, FAIL_OK};
		dir_tab[20] = '{1176, 1, 0, 0, 0, 0, FAIL_OK};
		dir_tab[21] = '{1101, 1, 0, 0, 0, 0, FAIL_OK};
		dir_tab[22] = '{1033, 1, 0, 0, 0, 0, FAIL_OK};
		dir_tab[23] = '{972, 1, 0, 0, 0, 0, FAIL_OK};
		dir_tab[24] = '{917, 1, 1, 0, 0, 0, FAIL_OK};
	end

	initial begin
		ach_word_t row_res;
		reg_val[REG_OUTDOOR]  = 16'd420;
		reg_val[REG_RISE_TOL] = 16'd20;
		reg_val[REG_MIN_RUN]  = 16'd10;
		reg_val[REG_MIN_EXC]  = 16'd200;
		reg_val[REG_MIN_DROP] = 16'd150;
		reg_val[REG_MIN_R2]   = 16'd52429;
		reg_val[REG_MAX_ACH]  = 16'd5120;
		clear_decay_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings
		foreach (dir_tab[i]) begin
			row_res.ach = 14'(dir_tab[i].ach);
			row_res.ach_ok = dir_tab[i].ach_ok;
			row_res.why = dir_tab[i].why;
			send_word(dir_tab[i].ppm, dir_tab[i].valid, dir_tab[i].last,
			          dir_tab[i].typed, row_res);
		end

		// random part: settings change only once the core is idle
		drain_results();
		new_setting();
		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			random_history();
			if ($urandom_range(0, 5) == 0) begin
				drain_results();
				new_setting();
			end
		end
		drain_results();

		if (mismatch_cnt == 0 && ach_expect_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
